>>> hdl/euclidean_distance_macros.svh
// Assertion macros shared by the euclidean distance RTL.
`ifndef EUCLIDEAN_DISTANCE_MACROS_SVH
`define EUCLIDEAN_DISTANCE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define ED_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("euclidean_distance assertion failed");
// Next-cycle implication
`define ED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("euclidean_distance assertion failed");
`else
`define ED_ASSERT_NOW(label, clk, rst, ante, cons)
`define ED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/ed_pkg.sv
// Package for the euclidean distance block: widths, state encoding, control structs.
`default_nettype none

package ed_pkg;

  localparam int ELEMENT_BITS_DEF = 16;
  localparam int SUM_W            = 46;
  localparam int DIST_W           = 23;
  localparam int ROOT_CNT_W       = $clog2(DIST_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_ROOT,
    S_DONE
  } ed_state_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic root_step;
    logic finish;
  } ed_ctrl_t;

  typedef struct packed {
    logic [DIST_W-1:0] root;
    logic              clipped;
  } ed_status_t;

endpackage

`default_nettype wire

>>> hdl/euclidean_distance.sv
// Euclidean distance, streamed: each element pair transfer (signed Q8.8) adds the squared
// difference to a saturating 46-bit Q30.16 sum; the pair marked last_element also yields
// distance = floor(sqrt(sum)) in Q15.8 plus a saturated flag, then the sum is cleared.
// A pair that is not last occupies the block while it is captured, squared and accumulated.
// The last pair then goes through the root steps and the done state before the result register
// loads; the square root is worked out one result bit per cycle on the same 47-bit add/subtract
// unit that does the accumulation. elem_ready is low while a pair is in work; a finished
// result waits in its own register without holding back the next pair, but a further
// result cannot load until the previous one has been taken.
`default_nettype none

`include "euclidean_distance_macros.svh"

module euclidean_distance #(
  parameter int ELEMENT_BITS = ed_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             elem_valid,
  output logic                                  elem_ready,
  input  wire logic signed [ELEMENT_BITS-1:0]   elem_a,
  input  wire logic signed [ELEMENT_BITS-1:0]   elem_b,
  input  wire logic                             last_element,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [ed_pkg::DIST_W-1:0]             distance,
  output logic                                  saturated
);

  ed_pkg::ed_state_t             state;
  ed_pkg::ed_state_t             state_next;
  logic [ed_pkg::ROOT_CNT_W-1:0] root_cnt;
  logic                          last_q;
  logic                          load_result;
  ed_pkg::ed_ctrl_t              ctrl;
  ed_pkg::ed_status_t            status;

  assign load_result = (state == ed_pkg::S_DONE) && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ed_pkg::S_IDLE: begin
        if (elem_valid) state_next = ed_pkg::S_SQUARE;
      end
      ed_pkg::S_SQUARE: begin
        state_next = ed_pkg::S_ACCUM;
      end
      ed_pkg::S_ACCUM: begin
        state_next = last_q ? ed_pkg::S_ROOT : ed_pkg::S_IDLE;
      end
      ed_pkg::S_ROOT: begin
        if (root_cnt == '0) state_next = ed_pkg::S_DONE;
      end
      ed_pkg::S_DONE: begin
        if (load_result) state_next = ed_pkg::S_IDLE;
      end
      default: state_next = ed_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    elem_ready     = 1'b0;
    ctrl.load_in   = 1'b0;
    ctrl.square    = 1'b0;
    ctrl.accum     = 1'b0;
    ctrl.root_step = 1'b0;
    ctrl.finish    = 1'b0;
    unique case (state)
      ed_pkg::S_IDLE: begin
        elem_ready   = 1'b1;
        ctrl.load_in = elem_valid;
      end
      ed_pkg::S_SQUARE: ctrl.square    = 1'b1;
      ed_pkg::S_ACCUM:  ctrl.accum     = 1'b1;
      ed_pkg::S_ROOT:   ctrl.root_step = 1'b1;
      ed_pkg::S_DONE:   ctrl.finish    = load_result;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      last_q <= last_element;
    end
    if (ctrl.accum) begin
      root_cnt <= ed_pkg::ROOT_CNT_W'(ed_pkg::DIST_W - 1);
    end else if (ctrl.root_step) begin
      root_cnt <= root_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      distance  <= status.root;
      saturated <= status.clipped;
    end
  end

  ed_datapath #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .elem_a (elem_a),
    .elem_b (elem_b),
    .ctrl   (ctrl),
    .status (status)
  );

  `ED_ASSERT_NEXT(a_root_len, clk, rst, (state == ed_pkg::S_ROOT) && (root_cnt == '0), state == ed_pkg::S_DONE)
  `ED_ASSERT_NEXT(a_take_pair, clk, rst, elem_valid && elem_ready, state == ed_pkg::S_SQUARE)
  `ED_ASSERT_NOW(a_sat_root, clk, rst, load_result && status.clipped, status.root == '1)
  `ED_ASSERT_NEXT(a_result_loads, clk, rst, load_result, result_valid && (state == ed_pkg::S_IDLE))

endmodule

`default_nettype wire

>>> hdl/ed_datapath.sv
// Datapath: element registers, squarer, shared add/subtract unit, sum and root registers.
`default_nettype none

`include "euclidean_distance_macros.svh"

module ed_datapath #(
  parameter int ELEMENT_BITS = ed_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic signed [ELEMENT_BITS-1:0] elem_a,
  input  wire logic signed [ELEMENT_BITS-1:0] elem_b,
  input  wire ed_pkg::ed_ctrl_t               ctrl,
  output ed_pkg::ed_status_t                  status
);

  localparam int SQ_W  = 2 * ELEMENT_BITS;
  localparam int ADD_W = (SQ_W + 1 > ed_pkg::SUM_W + 1) ? SQ_W + 1 : ed_pkg::SUM_W + 1;
  localparam int REM_W = ed_pkg::DIST_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic signed [ELEMENT_BITS-1:0] a_q;
  logic signed [ELEMENT_BITS-1:0] b_q;
  logic [SQ_W-1:0]                sq;
  logic [ed_pkg::SUM_W-1:0]       sum_of_squares;
  logic                           sum_clipped;
  logic [REM_W-1:0]               rem;
  logic [ed_pkg::DIST_W-1:0]      root;

  logic signed [ELEMENT_BITS:0]   diff;
  logic [ELEMENT_BITS-1:0]        mag;
  logic [SQ_W-1:0]                prod;
  logic [TRY_W-1:0]               try_a;
  logic [TRY_W-1:0]               try_b;
  logic [ADD_W-1:0]               op_a;
  logic [ADD_W-1:0]               op_b;
  logic                           sub;
  logic [ADD_W-1:0]               add_res;
  logic                           over;
  logic                           fits;

  assign diff = {a_q[ELEMENT_BITS-1], a_q} - {b_q[ELEMENT_BITS-1], b_q};
  assign mag  = diff[ELEMENT_BITS] ? ELEMENT_BITS'(-diff) : diff[ELEMENT_BITS-1:0];
  assign prod = SQ_W'(mag) * SQ_W'(mag);

  // root step: bring down two bits of the sum, trial subtract 4*root+1
  assign try_a = {rem, sum_of_squares[ed_pkg::SUM_W-1 -: 2]};
  assign try_b = TRY_W'({root, 2'b01});

  // shared adder
  always_comb begin
    if (ctrl.root_step) begin
      op_a = ADD_W'(try_a);
      op_b = ADD_W'(try_b);
      sub  = 1'b1;
    end else begin
      op_a = ADD_W'(sum_of_squares);
      op_b = ADD_W'(sq);
      sub  = 1'b0;
    end
  end

  assign add_res = op_a + (op_b ^ {ADD_W{sub}}) + ADD_W'(sub);
  assign over    = |add_res[ADD_W-1:ed_pkg::SUM_W];
  assign fits    = ~add_res[ADD_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      a_q <= elem_a;
      b_q <= elem_b;
    end
    if (ctrl.square) begin
      sq <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_of_squares <= '0;
      sum_clipped    <= 1'b0;
      rem            <= '0;
      root           <= '0;
    end else begin
      if (ctrl.accum) begin
        if (over) begin
          sum_of_squares <= '1;
          sum_clipped    <= 1'b1;
        end else begin
          sum_of_squares <= add_res[ed_pkg::SUM_W-1:0];
        end
        rem  <= '0;
        root <= '0;
      end
      if (ctrl.root_step) begin
        sum_of_squares <= {sum_of_squares[ed_pkg::SUM_W-3:0], 2'b00};
        if (fits) begin
          rem  <= add_res[REM_W-1:0];
          root <= {root[ed_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem  <= try_a[REM_W-1:0];
          root <= {root[ed_pkg::DIST_W-2:0], 1'b0};
        end
      end
      if (ctrl.finish) begin
        sum_clipped <= 1'b0;
      end
    end
  end

  assign status.root    = root;
  assign status.clipped = sum_clipped;

  // all sum bits are shifted out by the time the root is complete
  `ED_ASSERT_NOW(a_sum_drained, clk, rst, ctrl.finish, sum_of_squares == '0)
  // restoring root remainder never exceeds twice the partial root
  `ED_ASSERT_NOW(a_rem_bound, clk, rst, 1'b1, rem <= REM_W'({root, 1'b0}))

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for euclidean_distance: directed table, then random vectors.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [ed_pkg::DIST_W-1:0] dist_val;
    logic                      sat;
  } dist_result_t;

  typedef struct packed {
    logic [15:0]  a;
    logic [15:0]  b;
    logic         last;
    int           reps;
    bit           fixed_exp;
    dist_result_t res;
  } stim_row_t;

  localparam longint unsigned SUM_LIMIT = (64'd1 << ed_pkg::SUM_W) - 64'd1;
  localparam int              HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        elem_valid = 1'b0;
  logic [15:0] elem_a = '0;
  logic [15:0] elem_b = '0;
  logic        last_element = 1'b0;
  logic        result_ready = 1'b0;
  logic        elem_ready;
  logic        result_valid;
  logic [ed_pkg::DIST_W-1:0] distance;
  logic        saturated;

  longint unsigned sum_sq = 0;
  bit              clip_seen = 1'b0;
  bit              send_burst = 1'b0;
  int              mismatch_count = 0;
  dist_result_t    pending_distances[$];

  // 16384 full-scale pairs leave the sum just below its limit
  stim_row_t directed_rows [21] = '{
    '{16'h0000, 16'h0000, 1'b1, 1,     1'b1, '{23'd0, 1'b0}},
    '{16'h7fff, 16'h8000, 1'b1, 1,     1'b1, '{23'd65535, 1'b0}},
    '{16'h8000, 16'h7fff, 1'b1, 1,     1'b1, '{23'd65535, 1'b0}},
    '{16'h7fff, 16'h7fff, 1'b1, 1,     1'b1, '{23'd0, 1'b0}},
    '{16'h8000, 16'h8000, 1'b1, 1,     1'b1, '{23'd0, 1'b0}},
    '{16'h0100, 16'h0000, 1'b1, 1,     1'b1, '{23'd256, 1'b0}},
    '{16'hff00, 16'h0100, 1'b1, 1,     1'b1, '{23'd512, 1'b0}},
    '{16'h0003, 16'h0000, 1'b0, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'h0000, 16'h0004, 1'b1, 1,     1'b1, '{23'd5, 1'b0}},
    '{16'h0001, 16'h0000, 1'b0, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'hffff, 16'h0000, 1'b0, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'h5555, 16'haaaa, 1'b0, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'haaaa, 16'h5555, 1'b1, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'h7fff, 16'h0000, 1'b0, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'h0000, 16'h8000, 1'b1, 1,     1'b0, '{23'd0, 1'b0}},
    '{16'h7fff, 16'h8000, 1'b0, 16400, 1'b0, '{23'd0, 1'b0}},
    '{16'h0000, 16'h0000, 1'b1, 1,     1'b1, '{23'd8388607, 1'b1}},
    '{16'h0000, 16'h0000, 1'b1, 1,     1'b1, '{23'd0, 1'b0}},
    '{16'h8000, 16'h7fff, 1'b0, 16384, 1'b0, '{23'd0, 1'b0}},
    '{16'h8000, 16'h7fff, 1'b1, 1,     1'b1, '{23'd8388607, 1'b1}},
    '{16'h1234, 16'hfedc, 1'b1, 1,     1'b0, '{23'd0, 1'b0}}
  };

  euclidean_distance DUT (
    .clk          (clk),
    .rst          (rst),
    .elem_valid   (elem_valid),
    .elem_ready   (elem_ready),
    .elem_a       (elem_a),
    .elem_b       (elem_b),
    .last_element (last_element),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .distance     (distance),
    .saturated    (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ed_pkg::DIST_W-1:0] floor_root(input longint unsigned n);
    logic [ed_pkg::DIST_W-1:0] root;
    logic [ed_pkg::DIST_W-1:0] trial;
    longint unsigned           trial_sq;
    root = '0;
    for (int i = ed_pkg::DIST_W - 1; i >= 0; i--) begin
      trial = root | (ed_pkg::DIST_W'(1) << i);
      trial_sq = longint'(trial) * longint'(trial);
      if (trial_sq <= n) root = trial;
    end
    return root;
  endfunction

  function automatic void accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                          input logic last, output bit has_result,
                                          output dist_result_t res);
    longint          diff;
    longint unsigned sq;
    diff = longint'(a) - longint'(b);
    sq = (diff < 0) ? -diff : diff;
    sq = sq * sq;
    if (sq > SUM_LIMIT - sum_sq) begin
      sum_sq = SUM_LIMIT;
      clip_seen = 1'b1;
    end else begin
      sum_sq = sum_sq + sq;
    end
    has_result = last;
    res.dist_val = floor_root(sum_sq);
    res.sat = clip_seen;
    if (last) begin
      sum_sq = 0;
      clip_seen = 1'b0;
    end
  endfunction

  function automatic logic [15:0] pick_elem(input int style);
    logic [15:0] corners [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return corners[$urandom_range(0, 4)];
      default: return 16'($urandom_range(0, 511) - 256);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                           input bit fixed_exp, input dist_result_t fixed_res);
    int           gap;
    bit           has_result;
    dist_result_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      elem_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_valid <= 1'b1;
    elem_a <= a;
    elem_b <= b;
    last_element <= last;
    do @(posedge clk); while (!elem_ready);
    accumulate_pair(a, b, last, has_result, predicted);
    if (has_result) pending_distances.push_back(fixed_exp ? fixed_res : predicted);
  endtask

  task automatic check_result(input logic [ed_pkg::DIST_W-1:0] got_dist, input logic got_sat);
    dist_result_t want;
    if (pending_distances.size() == 0) begin
      report_mismatch($sformatf("unexpected result distance=%0d saturated=%0b",
                                got_dist, got_sat));
    end else begin
      want = pending_distances.pop_front();
      if (got_dist !== want.dist_val)
        report_mismatch($sformatf("distance %0d, expected %0d", got_dist, want.dist_val));
      if (got_sat !== want.sat)
        report_mismatch($sformatf("saturated %0b, expected %0b", got_sat, want.sat));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(distance, saturated);
  end

  // result side: random stalls, quiet stretches, and long hold-offs to back up the input
  initial begin
    int  gap;
    int  taken;
    bit  quiet;
    taken = 0;
    quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == 12 || taken == 80) gap = HOLD_CYCLES;
      else gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      taken++;
    end
  end

  initial begin
    int          n_items;
    int          len;
    int          style;
    logic [15:0] a;
    logic [15:0] b;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++)
        send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                  directed_rows[i].fixed_exp, directed_rows[i].res);
    end

    n_items = 0;
    while (n_items < 1000) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      send_burst = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        a = pick_elem(style == 3 ? $urandom_range(0, 2) : style);
        b = pick_elem(style == 3 ? $urandom_range(0, 2) : style);
        if (style == 2) b = a + 16'($urandom_range(0, 31) - 16);
        send_pair(a, b, (i == len - 1), 1'b0, '0);
        n_items++;
      end
    end
    elem_valid <= 1'b0;

    while (pending_distances.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0)
      $display("[euclidean_distance] OK");
    else
      $display("[euclidean_distance] ERROR");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[euclidean_distance] ERROR");
    $finish;
  end

endmodule
